### design/rsq_pkg.sv
// Shared types and constants for the rate step quantizer.
// Used by rsq_ctrl, rsq_datapath and rate_step_quantizer_unit; depends on nothing.
package rsq_pkg;

    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_THR  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR0  = 4'd2;

    localparam int THR_W  = 24;
    localparam int FRAC_W = 16;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NO_ANCHOR = 2'd1;
    localparam t_status ST_OVERFLOW  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_MUL_LO,
        S_MUL_HI,
        S_WRITE,
        S_LOOK,
        S_DIV,
        S_ROUND,
        S_READ,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    scan_init;
        logic    scan_step;
        logic    walk_init;
        logic    mul_lo;
        logic    mul_hi;
        logic    walk_wr;
        logic    walk_next;
        logic    set_st;
        t_status st_code;
        logic    look;
        logic    div_step;
        logic    round;
        logic    rd;
    } t_cmd;

    typedef struct packed {
        logic cfg_hit;
        logic scan_last;
        logic top_zero;
        logic walk_last;
        logic walk_full;
        logic build_ok;
        logic need_div;
        logic div_last;
    } t_sts;

endpackage

### design/rsq_ctrl.sv
// Controller state machine of the rate step quantizer.
// Depends on rsq_pkg; drives rsq_datapath through t_cmd and reads t_sts.
module rsq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  rsq_pkg::t_sts i_sts,
    output rsq_pkg::t_cmd o_cmd,
    output logic          busy,
    output logic          o_done
);
    import rsq_pkg::*;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    // Next state and the table-ready flag.
    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.cfg_hit) n_ready = 1'b0;
                if (start) n_state = r_ready ? S_LOOK : S_SCAN;
            end
            S_SCAN:   if (i_sts.scan_last) n_state = S_CHECK;
            S_CHECK: begin
                if (i_sts.top_zero) begin
                    n_ready = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_WRITE;
            S_WRITE: begin
                priority if (i_sts.walk_last) begin
                    n_ready = 1'b1;
                    n_state = S_LOOK;
                end else if (i_sts.walk_full) begin
                    n_ready = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_MUL_LO;
                end
            end
            S_LOOK: begin
                priority if (!i_sts.build_ok) n_state = S_OUT;
                else if (i_sts.need_div)      n_state = S_DIV;
                else                          n_state = S_READ;
            end
            S_DIV:    if (i_sts.div_last) n_state = S_ROUND;
            S_ROUND:  n_state = S_READ;
            S_READ:   n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        o_cmd.st_code = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept    = start;
                o_cmd.scan_init = start && !r_ready;
            end
            S_SCAN:   o_cmd.scan_step = 1'b1;
            S_CHECK: begin
                o_cmd.walk_init = 1'b1;
                o_cmd.set_st    = i_sts.top_zero;
                o_cmd.st_code   = ST_NO_ANCHOR;
            end
            S_MUL_LO: o_cmd.mul_lo = 1'b1;
            S_MUL_HI: o_cmd.mul_hi = 1'b1;
            S_WRITE: begin
                o_cmd.walk_wr   = 1'b1;
                o_cmd.walk_next = !i_sts.walk_last && !i_sts.walk_full;
                o_cmd.set_st    = i_sts.walk_last || i_sts.walk_full;
                o_cmd.st_code   = i_sts.walk_last ? ST_OK : ST_OVERFLOW;
            end
            S_LOOK:   o_cmd.look     = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_ROUND:  o_cmd.round    = 1'b1;
            S_READ:   o_cmd.rd       = 1'b1;
            S_OUT:    o_cmd = '0;
            default:  o_cmd = '0;
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);

endmodule

### design/rsq_datapath.sv
// Datapath of the rate step quantizer: configuration, table walk, divider, level memory.
// Depends on rsq_pkg; commanded by rsq_ctrl.
module rsq_datapath #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int ANCHOR_COUNT = 6,
    parameter int RATE_BITS    = 40,
    parameter int CFG_W        = 40
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rsq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]                 i_cfg_data,
    input  logic [RATE_BITS-4:0]             i_rate_bytes,
    input  rsq_pkg::t_cmd                    i_cmd,
    output rsq_pkg::t_sts                    o_sts,
    output logic [RATE_BITS-1:0]             o_quantized_rate,
    output rsq_pkg::t_status                 o_status
);
    import rsq_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int AW = (ANCHOR_COUNT > 1) ? $clog2(ANCHOR_COUNT) : 1;
    localparam int CW = (RATE_BITS > 1) ? $clog2(RATE_BITS) : 1;
    localparam int LW = RATE_BITS / 2;
    localparam int HW = RATE_BITS - LW;
    localparam int PW = RATE_BITS + THR_W;

    // Configuration registers.
    logic [RATE_BITS-1:0] r_min_step;
    logic [THR_W-1:0]     r_thr;
    logic [RATE_BITS-1:0] r_anchor [ANCHOR_COUNT];
    logic                 cfg_hit;

    always_comb begin
        cfg_hit = (i_cfg_idx == REG_MIN_STEP) || (i_cfg_idx == REG_ERR_THR);
        for (int a = 0; a < ANCHOR_COUNT; a++) begin
            if (i_cfg_idx == REG_ANCHOR0 + CFG_IDX_W'(a)) cfg_hit = 1'b1;
        end
        cfg_hit = cfg_hit && i_cfg_we;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_step <= RATE_BITS'(1);
            r_thr      <= '0;
            for (int a = 0; a < ANCHOR_COUNT; a++) r_anchor[a] <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MIN_STEP) r_min_step <= i_cfg_data[RATE_BITS-1:0];
            if (i_cfg_idx == REG_ERR_THR)  r_thr      <= i_cfg_data[THR_W-1:0];
            for (int a = 0; a < ANCHOR_COUNT; a++) begin
                if (i_cfg_idx == REG_ANCHOR0 + CFG_IDX_W'(a))
                    r_anchor[a] <= i_cfg_data[RATE_BITS-1:0];
            end
        end
    end

    logic [RATE_BITS-1:0] step;
    assign step = (r_min_step == '0) ? RATE_BITS'(1) : r_min_step;

    // Build and lookup state.
    logic [RATE_BITS-1:0]   r_rate, r_top, r_key, r_held, r_min_key;
    logic [AW-1:0]          r_aidx;
    logic [IW-1:0]          r_i, r_last, r_idx;
    logic [THR_W+LW-1:0]    r_plo;
    logic [THR_W+HW-1:0]    r_phi;
    logic [RATE_BITS-1:0]   r_rem;
    logic [RATE_BITS-1:0]   r_dvd;
    logic [CW-1:0]          r_cnt;
    t_status                r_status;
    logic [RATE_BITS-1:0]   r_rd_data;
    logic [RATE_BITS-1:0]   mem [TABLE_DEPTH];

    logic                   is_anc, reached;
    logic [RATE_BITS-1:0]   held_n;
    logic [PW-1:0]          lhs, rhs;
    logic [RATE_BITS:0]     rem_sh;
    logic                   q_bit;
    logic [RATE_BITS-1:0]   rem_r;

    always_comb begin
        is_anc = 1'b0;
        for (int a = 0; a < ANCHOR_COUNT; a++) begin
            if (r_anchor[a] != '0 && r_anchor[a] == r_key) is_anc = 1'b1;
        end
        lhs     = PW'({r_held - r_key, {FRAC_W{1'b0}}});
        rhs     = (PW'(r_phi) << LW) + PW'(r_plo);
        reached = (lhs >= rhs);
        held_n  = (is_anc || reached) ? r_key : r_held;
        rem_sh  = {r_rem, r_dvd[RATE_BITS-1]};
        q_bit   = (rem_sh >= {1'b0, step});
        rem_r   = r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_rate <= {i_rate_bytes, 3'b000};
        if (i_cmd.scan_init) begin
            r_top  <= '0;
            r_aidx <= '0;
        end
        if (i_cmd.scan_step) begin
            if (r_anchor[r_aidx] > r_top) r_top <= r_anchor[r_aidx];
            r_aidx <= r_aidx + AW'(1);
        end
        if (i_cmd.walk_init) begin
            r_key  <= r_top;
            r_held <= r_top;
            r_i    <= '0;
        end
        if (i_cmd.mul_lo) r_plo <= r_thr * r_key[LW-1:0];
        if (i_cmd.mul_hi) r_phi <= r_thr * r_key[RATE_BITS-1:LW];
        if (i_cmd.walk_wr) begin
            r_held <= held_n;
            if (r_key <= step) begin
                r_last    <= r_i;
                r_min_key <= r_key;
            end
        end
        if (i_cmd.walk_next) begin
            r_key <= r_key - step;
            r_i   <= r_i + IW'(1);
        end
        if (i_cmd.look) begin
            if (r_rate >= r_top)          r_idx <= '0;
            else if (r_rate <= r_min_key) r_idx <= r_last;
            r_dvd <= r_top - r_rate;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? RATE_BITS'(rem_sh - {1'b0, step}) : rem_sh[RATE_BITS-1:0];
            r_dvd <= {r_dvd[RATE_BITS-2:0], q_bit};
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.round) begin
            if (rem_r == '0 || rem_r <= step - rem_r) r_idx <= r_dvd[IW-1:0];
            else                                      r_idx <= r_dvd[IW-1:0] + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)          r_status <= ST_NO_ANCHOR;
        else if (i_cmd.set_st) r_status <= i_cmd.st_code;
    end

    // Level memory: one write port for the walk, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_wr) mem[r_i] <= held_n;
        if (i_cmd.rd)      r_rd_data <= mem[r_idx];
    end

    always_comb begin
        o_sts.cfg_hit   = cfg_hit;
        o_sts.scan_last = (r_aidx == AW'(ANCHOR_COUNT - 1));
        o_sts.top_zero  = (r_top == '0);
        o_sts.walk_last = (r_key <= step);
        o_sts.walk_full = (r_i == IW'(TABLE_DEPTH - 1));
        o_sts.build_ok  = (r_status == ST_OK);
        o_sts.need_div  = (r_rate < r_top) && (r_rate > r_min_key);
        o_sts.div_last  = (r_cnt == CW'(RATE_BITS - 1));
    end

    assign o_quantized_rate = (r_status == ST_OK) ? r_rd_data : '0;
    assign o_status         = r_status;

endmodule

### design/rate_step_quantizer_unit.sv
// Top level of the rate step quantizer: controller plus datapath.
// Depends on rsq_pkg, rsq_ctrl and rsq_datapath.
//
//   Channel   Ports                                   Handshake
//   input     i_rate_bytes                            start high while busy low
//   result    o_quantized_rate, o_status              o_done strobe, one cycle
//   config    i_cfg_we, i_cfg_idx, i_cfg_data         i_cfg_we, no wait
//
// A lookup on a built table reads the level memory directly when the rate clamps
// to an end key; otherwise the one-bit-per-cycle restoring divider first finds the
// key index. The first word after reset or after a configuration write made while
// idle also rebuilds the table: a scan over the anchors finds the top anchor, a
// check step tests it, then each key takes two partial products and a memory
// write.
// Reset is synchronous and active low; the table memory is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module rate_step_quantizer_unit #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int ANCHOR_COUNT = 6,
    parameter int RATE_BITS    = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [RATE_BITS-4:0]          i_rate_bytes,
    output logic                          o_done,
    output logic [RATE_BITS-1:0]          o_quantized_rate,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_we,
    input  logic [rsq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [((RATE_BITS > 24) ? RATE_BITS : 24)-1:0] i_cfg_data
);
    import rsq_pkg::*;

    localparam int CFG_W = (RATE_BITS > THR_W) ? RATE_BITS : THR_W;

    t_cmd    cmd;
    t_sts    sts;
    t_status status;

    rsq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    rsq_datapath #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .ANCHOR_COUNT (ANCHOR_COUNT),
        .RATE_BITS    (RATE_BITS),
        .CFG_W        (CFG_W)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_rate_bytes     (i_rate_bytes),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_quantized_rate (o_quantized_rate),
        .o_status         (status)
    );

    assign o_status = status;

    // A result always returns the unit to idle on the next cycle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy) else $error("unit still busy after a result");

    // An accepted word makes the unit busy.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted word did not start");

    // Error results carry a zero rate.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_quantized_rate == '0))
        else $error("error result with nonzero rate");

    // Status codes stay within the defined set.
    a_st_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_OK || o_status == ST_NO_ANCHOR ||
                    o_status == ST_OVERFLOW)) else $error("undefined status");

endmodule
